FILE: rtl/core/rpd_pkg.sv
`default_nettype none
package rpd_pkg;

  localparam logic [7:0] BroadcastAddr = 8'd255;
  localparam logic [7:0] MinLength     = 8'd4;
  localparam logic [7:0] LengthIndex   = 8'd3;

  typedef enum logic [0:0] {
    OP_RX_BYTE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] write_index;
    logic [7:0] write_byte;
    logic       packet_done;
    logic [7:0] packet_length;
    logic       flush_request;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/rpd_core.sv
`default_nettype none
module rpd_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_en_i,
  input  wire logic            operation_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic [7:0]      device_address_i,
  output rpd_pkg::result_t     result_o
);
  import rpd_pkg::*;

  logic       packet_ready_q, packet_ready_d;
  logic       receiving_q, receiving_d;
  logic [7:0] byte_position_q, byte_position_d;
  logic [7:0] expected_length_q, expected_length_d;
  logic [7:0] pos_inc;
  logic [7:0] exp_new;
  result_t    res;

  assign pos_inc = byte_position_q + 8'd1;
  assign exp_new = (byte_position_q == LengthIndex) ? rx_byte_i : expected_length_q;

  always_comb begin
    res               = '0;
    packet_ready_d    = packet_ready_q;
    receiving_d       = receiving_q;
    byte_position_d   = byte_position_q;
    expected_length_d = expected_length_q;
    priority if (operation_i == OP_RELEASE) begin
      packet_ready_d = 1'b0;
    end else if (packet_ready_q) begin
      res.flush_request = 1'b1;
    end else if (receiving_q &&
                 (byte_position_q < MinLength || byte_position_q < expected_length_q)) begin
      expected_length_d = exp_new;
      res.write_valid   = 1'b1;
      res.write_index   = byte_position_q;
      res.write_byte    = rx_byte_i;
      byte_position_d   = pos_inc;
      if (pos_inc >= exp_new && pos_inc > MinLength) begin
        packet_ready_d      = 1'b1;
        res.packet_done     = 1'b1;
        res.packet_length   = pos_inc;
        receiving_d         = 1'b0;
        byte_position_d     = '0;
        res.flush_request   = 1'b1;
      end
    end else if (!receiving_q) begin
      if (rx_byte_i == device_address_i || rx_byte_i == BroadcastAddr) begin
        res.write_valid = 1'b1;
        res.write_index = byte_position_q;
        res.write_byte  = rx_byte_i;
        receiving_d     = 1'b1;
        byte_position_d = pos_inc;
      end else begin
        res.flush_request = 1'b1;
      end
    end else begin
      // short length: drop the byte and close the packet
      packet_ready_d    = 1'b1;
      res.packet_done   = 1'b1;
      res.packet_length = expected_length_q;
      byte_position_d   = '0;
      receiving_d       = 1'b0;
      res.flush_request = 1'b1;
    end
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_ready_q    <= 1'b0;
      receiving_q       <= 1'b0;
      byte_position_q   <= '0;
      expected_length_q <= '0;
    end else if (step_en_i) begin
      packet_ready_q    <= packet_ready_d;
      receiving_q       <= receiving_d;
      byte_position_q   <= byte_position_d;
      expected_length_q <= expected_length_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rpd_out_reg.sv
`default_nettype none
module rpd_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire rpd_pkg::result_t result_i,
  output logic                  advance_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rpd_pkg::result_t      result_o
);
  import rpd_pkg::*;

  logic    out_valid_q, out_valid_d;
  result_t result_q;

  assign advance_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (advance_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule
`default_nettype wire

FILE: rtl/core/radio_packet_deframer_unit.sv
// Radio packet deframer: turns received radio bytes into packet buffer writes.
// Input channel (in_valid_i/in_ready_o): operation_i = 0 delivers rx_byte_i,
// operation_i = 1 releases a completed packet buffer.
// Output channel (out_valid_o/out_ready_i): one result per input item, giving
// the buffer write (write_valid_o, write_index_o, write_byte_o), packet
// completion (packet_done_o, packet_length_o) and a FIFO resync request.
// Config channel (cfg_valid_i/cfg_ready_o): cfg_data_i sets the node address;
// write it only while no item is in flight.
// Timing: an accepted item is held in the input register, and its result is
// then loaded into the result register, where it stays valid until taken.
// Throughput: one item per cycle while out_ready_i is high; the per-item
// decision is a single compare-and-count step on the packet state.
// Reset: clears the node address, packet state and both valid flags.
// Stall: while out_ready_i is low the result register holds and the input
// register fills; in_ready_o drops once both are occupied, with no item lost.
`default_nettype none
module radio_packet_deframer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       operation_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            write_valid_o,
  output logic [7:0]      write_index_o,
  output logic [7:0]      write_byte_o,
  output logic            packet_done_o,
  output logic [7:0]      packet_length_o,
  output logic            flush_request_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);
  import rpd_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic       operation_q;
  logic [7:0] rx_byte_q;
  logic [7:0] device_address_q;
  logic       advance;
  logic       step_en;
  result_t    core_result;
  result_t    out_result;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !in_valid_q || advance;
  assign step_en     = in_valid_q && advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q       <= 1'b0;
      device_address_q <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        device_address_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      operation_q <= operation_i;
      rx_byte_q   <= rx_byte_i;
    end
  end

  rpd_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_en_i        (step_en),
    .operation_i      (operation_q),
    .rx_byte_i        (rx_byte_q),
    .device_address_i (device_address_q),
    .result_o         (core_result)
  );

  rpd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_valid_q),
    .result_i    (core_result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign write_valid_o   = out_result.write_valid;
  assign write_index_o   = out_result.write_index;
  assign write_byte_o    = out_result.write_byte;
  assign packet_done_o   = out_result.packet_done;
  assign packet_length_o = out_result.packet_length;
  assign flush_request_o = out_result.flush_request;

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none
module tb;
  import rpd_pkg::*;

  localparam int CycleLimit = 200000;

  class packet_frame_tracker;
    logic [7:0] node_addr;
    logic       held;
    logic       rcv;
    logic [7:0] pos;
    logic [7:0] frame_len;
    result_t    due_results[$];
    int         errors;

    function new();
      node_addr = '0;
      held      = 1'b0;
      rcv       = 1'b0;
      pos       = '0;
      frame_len = '0;
      errors    = 0;
    endfunction

    function void set_address(logic [7:0] a);
      node_addr = a;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function bit collecting();
      return rcv && !held;
    endfunction

    function logic [7:0] position();
      return pos;
    endfunction

    function void note_item(op_e op, logic [7:0] b);
      result_t r;
      r = '0;
      if (op == OP_RELEASE) begin
        held = 1'b0;
      end else if (held) begin
        r.flush_request = 1'b1;
      end else if (rcv && (pos < MinLength || pos < frame_len)) begin
        if (pos == LengthIndex) frame_len = b;
        r.write_valid = 1'b1;
        r.write_index = pos;
        r.write_byte  = b;
        pos = pos + 8'd1;
        if (pos >= frame_len && pos > MinLength) begin
          held            = 1'b1;
          r.packet_done   = 1'b1;
          r.packet_length = pos;
          rcv             = 1'b0;
          pos             = '0;
          r.flush_request = 1'b1;
        end
      end else if (!rcv) begin
        if (b == node_addr || b == BroadcastAddr) begin
          r.write_valid = 1'b1;
          r.write_index = pos;
          r.write_byte  = b;
          rcv = 1'b1;
          pos = pos + 8'd1;
        end else begin
          r.flush_request = 1'b1;
        end
      end else begin
        // short length: drop this byte and close the packet
        held            = 1'b1;
        r.packet_done   = 1'b1;
        r.packet_length = frame_len;
        pos             = '0;
        rcv             = 1'b0;
        r.flush_request = 1'b1;
      end
      due_results.push_back(r);
    endfunction

    function void cmp(string name, int want_v, int got_v);
      if (want_v != got_v) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected, got %h", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      cmp("write_valid", want.write_valid, got.write_valid);
      cmp("write_index", want.write_index, got.write_index);
      cmp("write_byte", want.write_byte, got.write_byte);
      cmp("packet_done", want.packet_done, got.packet_done);
      cmp("packet_length", want.packet_length, got.packet_length);
      cmp("flush_request", want.flush_request, got.flush_request);
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       operation_i = 1'b0;
  logic [7:0] rx_byte_i   = '0;
  logic       out_ready_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [7:0] cfg_data_i  = '0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       write_valid_o;
  logic [7:0] write_index_o;
  logic [7:0] write_byte_o;
  logic       packet_done_o;
  logic [7:0] packet_length_o;
  logic       flush_request_o;
  logic       cfg_ready_o;

  result_t seen;
  assign seen = {write_valid_o, write_index_o, write_byte_o,
                 packet_done_o, packet_length_o, flush_request_o};

  packet_frame_tracker tracker = new();
  bit steady = 1'b0;
  int items_sent = 0;
  int cycles = 0;

  radio_packet_deframer_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_valid_o  (write_valid_o),
    .write_index_o  (write_index_o),
    .write_byte_o   (write_byte_o),
    .packet_done_o  (packet_done_o),
    .packet_length_o(packet_length_o),
    .flush_request_o(flush_request_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) tracker.check_result(seen);
    out_ready_i <= steady || ($urandom_range(0, 99) >= 7);
  end

  task automatic push_item(input op_e op, input logic [7:0] b);
    if (!steady && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    rx_byte_i   <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_item(op, b);
    items_sent++;
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] a);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= a;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_address(a);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_packet(input logic [7:0] a, input bit longest);
    logic [7:0] len;
    int pick;
    pick = $urandom_range(0, 99);
    if (longest) len = 8'd255;
    else if (pick < 70) len = 8'($urandom_range(0, 12));
    else if (pick < 98) len = 8'($urandom_range(13, 40));
    else len = 8'($urandom_range(41, 255));
    push_item(OP_RX_BYTE, $urandom_range(0, 1) ? a : BroadcastAddr);
    while (tracker.collecting()) begin
      if (tracker.position() == LengthIndex) push_item(OP_RX_BYTE, len);
      else if ($urandom_range(0, 99) < 3) push_item(OP_RELEASE, 8'($urandom_range(0, 255)));
      else push_item(OP_RX_BYTE, 8'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(0, 2)) push_item(OP_RX_BYTE, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 90) push_item(OP_RELEASE, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 5) push_item(OP_RELEASE, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input logic [7:0] a, input int count, input bit longest);
    int target;
    write_address(a);
    target = items_sent + count;
    if (longest) send_packet(a, 1'b1);
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 80) send_packet(a, 1'b0);
      else if ($urandom_range(0, 99) < 30) push_item(OP_RELEASE, 8'($urandom_range(0, 255)));
      else push_item(OP_RX_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_address(8'h5A);
    push_item(OP_RELEASE, 8'hFF);
    push_item(OP_RX_BYTE, 8'h00);
    push_item(OP_RX_BYTE, 8'h5B);
    // broadcast start, zero length
    push_item(OP_RX_BYTE, 8'hFF);
    push_item(OP_RX_BYTE, 8'h11);
    push_item(OP_RX_BYTE, 8'h22);
    push_item(OP_RX_BYTE, 8'h00);
    push_item(OP_RX_BYTE, 8'h33);
    push_item(OP_RX_BYTE, 8'hAB);
    push_item(OP_RELEASE, 8'h00);
    // own address, length five
    push_item(OP_RX_BYTE, 8'h5A);
    push_item(OP_RX_BYTE, 8'h00);
    push_item(OP_RX_BYTE, 8'hFF);
    push_item(OP_RX_BYTE, 8'h05);
    push_item(OP_RX_BYTE, 8'h80);
    push_item(OP_RELEASE, 8'h00);
    // length four
    push_item(OP_RX_BYTE, 8'hFF);
    push_item(OP_RX_BYTE, 8'h01);
    push_item(OP_RX_BYTE, 8'h02);
    push_item(OP_RX_BYTE, 8'h04);
    push_item(OP_RX_BYTE, 8'h7E);
    push_item(OP_RELEASE, 8'h00);
    push_item(OP_RELEASE, 8'h55);

    run_phase(8'h00, 80, 1'b0);
    run_phase(8'hFF, 80, 1'b1);
    run_phase(8'($urandom_range(0, 255)), 80, 1'b0);
    steady = 1'b1;
    run_phase(8'($urandom_range(0, 255)), 80, 1'b0);
    steady = 1'b0;
    run_phase(8'h01, 80, 1'b0);

    settle();
    repeat (10) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/rpd_pkg.sv
rtl/core/rpd_core.sv
rtl/core/rpd_out_reg.sv
rtl/core/radio_packet_deframer_unit.sv
tb/sv/tb.sv
